>>> rtl/assert_macros.svh
// Assertion macros used by range_history_median_velocity.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define RHMV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication under synchronous active-low reset.
`define RHMV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/rhmv_pkg.sv
// Types and constants for the range history median and velocity block.
package rhmv_pkg;

  localparam int unsigned DIST_W   = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned VEL_W    = 27;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned NUM_W    = 26;
  localparam int unsigned ENTRY_W  = DIST_W + TIME_W;
  localparam int unsigned IN_DW    = 56;
  localparam int unsigned OUT_DW   = 96;
  localparam int unsigned VEL_SCALE = 1000;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PEEK = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

>>> rtl/range_history_median_velocity.sv
// Range history ring with median-of-three and velocity, memory based.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: action; tdata: distance, time, age_index
//  out_    | out | out_tvalid/tready  | tuser: peek_valid; tdata: median, velocity,
//          |     |                    |        fill_count, peek_distance, peek_time
//
//  One request at a time, in order: accept, memory reads (one read port), prepare,
//  a radix-2 divider run when a velocity is due, and the output load.
//  A new request is taken while the previous result waits in the output register.
//  Reset is synchronous and clears pointer, fill count and control; the memory is
//  not cleared. A stalled output holds the sequencer before the output load.
`include "assert_macros.svh"

module range_history_median_velocity #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // reading_distance[15:0], reading_time[47:16], age_index[55:48]
  input  logic        in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // median_distance[15:0], velocity[42:16], fill_count[47:43],
                                  // peek_distance[63:48], peek_time[95:64]
  output logic        out_tuser   // peek_valid[0]
);

  localparam int unsigned PW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned AW = PW + 1;

  rhmv_pkg::state_t state_r;

  logic [PW-1:0] wp_r;
  logic [CW-1:0] count_r;
  logic [2:0]    rd_cnt_r;
  logic [4:0]    div_cnt_r;

  logic [rhmv_pkg::ENTRY_W-1:0] mem [HISTORY_DEPTH];
  logic [rhmv_pkg::ENTRY_W-1:0] rdata_r;

  logic                        peek_ok_r;
  logic [PW-1:0]               peek_k_r;
  logic [rhmv_pkg::DIST_W-1:0] d0_r, d1_r, d2_r, pd_r, median_r;
  logic [rhmv_pkg::TIME_W-1:0] t0_r, t1_r, pt_r, dt_r, rem_r;
  logic [rhmv_pkg::NUM_W-1:0]  quo_r;
  logic                        neg_r, vel_ok_r;

  logic                        out_valid_r, out_user_r;
  logic [rhmv_pkg::OUT_DW-1:0] out_data_r;

  logic                        in_acc, is_push, out_free;
  logic [rhmv_pkg::DIST_W-1:0] in_dist;
  logic [rhmv_pkg::TIME_W-1:0] in_time;
  logic [rhmv_pkg::AGE_W-1:0]  in_age;
  logic [PW-1:0]               wp_inc, rd_k, rd_addr;
  logic [AW-1:0]               rd_sum;
  logic [rhmv_pkg::DIST_W-1:0] lo01, hi01, mid;
  logic [rhmv_pkg::DIST_W-1:0] mag;
  logic [rhmv_pkg::TIME_W:0]   trial;
  logic                        fit;
  logic [rhmv_pkg::VEL_W-1:0]  q_ext, vel;
  logic                        peek_ok_in;

  assign in_tready = (state_r == rhmv_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_push   = (in_tuser == rhmv_pkg::ACT_PUSH);
  assign in_dist   = in_tdata[15:0];
  assign in_time   = in_tdata[47:16];
  assign in_age    = in_tdata[55:48];
  assign out_free  = !out_valid_r || out_tready;

  assign wp_inc = (wp_r == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign peek_ok_in = !is_push && (9'(in_age) < 9'(count_r));

  always_comb begin
    case (rd_cnt_r)
      3'd0:    rd_k = '0;
      3'd1:    rd_k = PW'(1);
      3'd2:    rd_k = PW'(2);
      default: rd_k = peek_k_r;
    endcase
    rd_sum = AW'(wp_r) + AW'(HISTORY_DEPTH - 1) - AW'(rd_k);
    if (rd_sum >= AW'(HISTORY_DEPTH)) begin
      rd_addr = PW'(rd_sum - AW'(HISTORY_DEPTH));
    end else begin
      rd_addr = PW'(rd_sum);
    end
  end

  always_comb begin
    lo01 = (d0_r < d1_r) ? d0_r : d1_r;
    hi01 = (d0_r < d1_r) ? d1_r : d0_r;
    mid  = (hi01 < d2_r) ? hi01 : d2_r;
    if (lo01 > mid) begin
      mid = lo01;
    end
    mag   = (d0_r < d1_r) ? (d1_r - d0_r) : (d0_r - d1_r);
    trial = {rem_r, quo_r[rhmv_pkg::NUM_W-1]};
    fit   = (trial >= {1'b0, dt_r});
    q_ext = {1'b0, quo_r};
    if (!vel_ok_r) begin
      vel = '0;
    end else if (neg_r) begin
      vel = '0 - q_ext;
    end else begin
      vel = q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_push) begin
      mem[wp_r] <= {in_time, in_dist};
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhmv_pkg::S_IDLE;
      wp_r        <= '0;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == rhmv_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        rhmv_pkg::S_IDLE: begin
          if (in_acc) begin
            if (is_push) begin
              wp_r <= wp_inc;
              if (count_r != CW'(HISTORY_DEPTH)) begin
                count_r <= count_r + 1'b1;
              end
            end
            rd_cnt_r <= '0;
            state_r  <= rhmv_pkg::S_RD;
          end
        end
        rhmv_pkg::S_RD: begin
          if (rd_cnt_r == 3'd4) begin
            state_r <= rhmv_pkg::S_PREP;
          end else begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
        end
        rhmv_pkg::S_PREP: begin
          div_cnt_r <= '0;
          if (count_r >= CW'(2) && t0_r > t1_r) begin
            state_r <= rhmv_pkg::S_DIV;
          end else begin
            state_r <= rhmv_pkg::S_OUT;
          end
        end
        rhmv_pkg::S_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == 5'(rhmv_pkg::NUM_W - 1)) begin
            state_r <= rhmv_pkg::S_OUT;
          end
        end
        rhmv_pkg::S_OUT: begin
          if (out_free) begin
            state_r <= rhmv_pkg::S_IDLE;
          end
        end
        default: state_r <= rhmv_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      peek_ok_r <= peek_ok_in;
      peek_k_r  <= peek_ok_in ? PW'(in_age) : '0;
    end
    if (state_r == rhmv_pkg::S_RD) begin
      case (rd_cnt_r)
        3'd1: begin
          d0_r <= rdata_r[15:0];
          t0_r <= rdata_r[47:16];
        end
        3'd2: begin
          d1_r <= rdata_r[15:0];
          t1_r <= rdata_r[47:16];
        end
        3'd3: d2_r <= rdata_r[15:0];
        3'd4: begin
          pd_r <= peek_ok_r ? rdata_r[15:0] : '0;
          pt_r <= peek_ok_r ? rdata_r[47:16] : '0;
        end
        default: ;
      endcase
    end
    if (state_r == rhmv_pkg::S_PREP) begin
      if (count_r == '0) begin
        median_r <= '0;
      end else if (count_r < CW'(3)) begin
        median_r <= d0_r;
      end else begin
        median_r <= mid;
      end
      vel_ok_r <= (count_r >= CW'(2)) && (t0_r > t1_r);
      neg_r    <= d0_r < d1_r;
      dt_r     <= t0_r - t1_r;
      rem_r    <= '0;
      quo_r    <= rhmv_pkg::NUM_W'(mag) * rhmv_pkg::NUM_W'(rhmv_pkg::VEL_SCALE);
    end
    if (state_r == rhmv_pkg::S_DIV) begin
      rem_r <= fit ? rhmv_pkg::TIME_W'(trial - {1'b0, dt_r}) : trial[rhmv_pkg::TIME_W-1:0];
      quo_r <= {quo_r[rhmv_pkg::NUM_W-2:0], fit};
    end
    if (state_r == rhmv_pkg::S_OUT && out_free) begin
      out_user_r <= peek_ok_r;
      out_data_r <= {pt_r, pd_r, rhmv_pkg::FILL_W'(count_r), vel, median_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `RHMV_ASSERT_NXT(a_push_count, clk, rst_n, in_acc && is_push,
    (count_r == $past(count_r) + 1'b1) || (count_r == CW'(HISTORY_DEPTH)))
  `RHMV_ASSERT_NXT(a_out_load, clk, rst_n, (state_r == rhmv_pkg::S_OUT) && out_free,
    out_valid_r && (state_r == rhmv_pkg::S_IDLE))
  `RHMV_ASSERT_IMP(a_push_no_peek, clk, rst_n, out_valid_r && !out_user_r,
    (out_data_r[95:48] == '0))
  `RHMV_ASSERT_IMP(a_fill_bound, clk, rst_n, state_r != rhmv_pkg::S_IDLE,
    count_r <= CW'(HISTORY_DEPTH))

endmodule
